FILE: hw/rtl/bpa_pkg.sv
// Shared definitions for the buddy page allocator: command codes, default
// sizes and the controller state type. No dependencies.

package bpa_pkg;

  localparam int MAX_ORDER_DEF = 14;
  localparam int NUM_LISTS_DEF = 15;

  localparam logic [1:0] FUNC_ALLOC = 2'd0;
  localparam logic [1:0] FUNC_FREE  = 2'd1;
  localparam logic [1:0] FUNC_INIT  = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE,
    S_I_START,
    S_CLR,
    S_I_END,
    S_A_CHK,
    S_A_ORD,
    S_A_SCAN,
    S_A_SPLIT,
    S_A_MRD,
    S_A_MWR,
    S_F_CHK,
    S_F_RD,
    S_F_LOOP,
    S_F_BUD,
    S_F_NEXT,
    S_F_END,
    S_P_RD,
    S_P_WR,
    S_P_HW,
    S_U_RD,
    S_U_P,
    S_U_PW,
    S_U_N,
    S_U_NW,
    S_FAIL,
    S_DONE
  } state_t;

endpackage

FILE: hw/rtl/bpa_page_ram.sv
// Per-page table of the buddy allocator: one write port and one read port,
// read data registered. Depends on nothing.

module bpa_page_ram #(
  parameter int AW = 14,
  parameter int DW = 36
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/buddy_page_allocator_core.sv
// Buddy page allocator: sequencer over one page table memory holding the
// doubly linked free lists, page orders and in-use / free marks.
// Depends on bpa_pkg and bpa_page_ram.
//
//  channel   signals                                    direction
//  command   start, busy, func, request_pages,          in (taken: start & !busy)
//            page_index
//  result    done, ok, block_index, free_total          out (one cycle, one word)
//  config    cfg_we, cfg_data                           in (written when cfg_we)
//
// One command is processed at a time; busy is high from the cycle after
// acceptance until the result word has been shown. Allocate scans the free
// lists upward from the requested order (at most 15 orders) and splits the
// block it finds down to that order; free merges the block with its free buddy,
// one order at a time. All of this is bound by the single read and single write port of the page table.
// Reset and the init command both sweep the page table, one page per cycle,
// then put the whole pool as one block on its free list; only the init command
// ends with a result word, while after reset the block just returns to idle.
// The result is not held: the receiver must take the word in its strobe cycle.

module buddy_page_allocator_core #(
  parameter int MAX_ORDER = bpa_pkg::MAX_ORDER_DEF,
  parameter int NUM_LISTS = bpa_pkg::NUM_LISTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           func,
  input  logic [MAX_ORDER:0]   request_pages,
  input  logic [MAX_ORDER-1:0] page_index,
  output logic                 done,
  output logic                 ok,
  output logic [MAX_ORDER-1:0] block_index,
  output logic [MAX_ORDER:0]   free_total,
  input  logic                 cfg_we,
  input  logic [MAX_ORDER:0]   cfg_data
);

  import bpa_pkg::*;

  localparam int AW  = MAX_ORDER;
  localparam int LW  = MAX_ORDER + 1;
  localparam int OW  = $clog2(MAX_ORDER + 2);
  localparam int HW  = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam int TOP = (MAX_ORDER < NUM_LISTS - 1) ? MAX_ORDER : NUM_LISTS - 1;
  localparam int DW  = 2 * LW + OW + 2;
  localparam logic [LW-1:0] NIL = LW'(1) << MAX_ORDER;

  state_t state, state_next;
  state_t ret;

  logic [LW-1:0] pool_pages;
  logic [OW-1:0] pool_ord;
  logic [LW-1:0] fcount;
  logic [LW-1:0] heads [NUM_LISTS];
  logic          report;

  logic [1:0]    func_r;
  logic [LW-1:0] req_r;
  logic [AW-1:0] page_r;
  logic [AW:0]   clr_cnt;

  logic [OW-1:0] cur_ord;
  logic [AW-1:0] sp;
  logic [LW-1:0] tmp_h;
  logic [LW-1:0] un;
  logic [LW-1:0] upr;
  logic [OW-1:0] aord;
  logic [OW-1:0] scan;
  logic [AW-1:0] blk;
  logic [AW-1:0] fp;
  logic [AW-1:0] fb;
  logic [OW-1:0] ford;
  logic          ok_r;
  logic [AW-1:0] blk_r;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [DW-1:0] wdata, rdata;

  logic [LW-1:0] rd_next, rd_prev;
  logic [OW-1:0] rd_ord;
  logic          rd_use, rd_free;

  logic [LW-1:0] req0;
  logic [OW-1:0] ceil_ord;
  logic [OW-1:0] cfg_ord;
  logic [OW-1:0] free_ord;
  logic [LW-1:0] head_cur;
  logic [LW-1:0] head_scan;

  assign rd_next = rdata[DW-1 -: LW];
  assign rd_prev = rdata[DW-LW-1 -: LW];
  assign rd_ord  = rdata[OW+1:2];
  assign rd_use  = rdata[1];
  assign rd_free = rdata[0];

  assign head_cur  = heads[HW'(cur_ord)];
  assign head_scan = heads[HW'(scan)];

  assign req0 = (req_r == '0) ? LW'(1) : req_r;

  // Smallest order whose block size covers the request.
  always_comb begin
    ceil_ord = OW'(MAX_ORDER);
    for (int k = MAX_ORDER; k >= 0; k--) begin
      if ((LW'(1) << k) >= req0) begin
        ceil_ord = OW'(k);
      end
    end
  end

  // Floor log2 of the configured page count, capped at the top list.
  always_comb begin
    cfg_ord = '0;
    for (int k = 0; k <= MAX_ORDER; k++) begin
      if (pool_pages[k]) begin
        cfg_ord = OW'(k);
      end
    end
    if (cfg_ord > OW'(TOP)) begin
      cfg_ord = OW'(TOP);
    end
  end

  assign free_ord = (rd_ord > pool_ord) ? pool_ord : rd_ord;

  bpa_page_ram #(.AW(AW), .DW(DW)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (func)
            FUNC_ALLOC: state_next = S_A_CHK;
            FUNC_FREE:  state_next = S_F_CHK;
            FUNC_INIT:  state_next = S_I_START;
            default:    state_next = S_FAIL;
          endcase
        end
      end
      S_I_START: state_next = S_CLR;
      S_CLR:     state_next = (clr_cnt == (AW+1)'((2**AW) - 1)) ? S_P_RD : S_CLR;
      S_I_END:   state_next = report ? S_DONE : S_IDLE;
      S_A_CHK:   state_next = (req0 > fcount) ? S_FAIL : S_A_ORD;
      S_A_ORD:   state_next = (aord > pool_ord) ? S_FAIL : S_A_SCAN;
      S_A_SCAN: begin
        if (scan > pool_ord) begin
          state_next = S_FAIL;
        end else if (!head_scan[MAX_ORDER]) begin
          state_next = S_U_RD;
        end
      end
      S_A_SPLIT: state_next = (scan > aord) ? S_P_RD : S_A_MRD;
      S_A_MRD:   state_next = S_A_MWR;
      S_A_MWR:   state_next = S_DONE;
      S_F_CHK:   state_next = ((page_r >> pool_ord) != '0) ? S_FAIL : S_F_RD;
      S_F_RD:    state_next = rd_use ? S_F_LOOP : S_FAIL;
      S_F_LOOP:  state_next = (ford < pool_ord) ? S_F_BUD : S_P_RD;
      S_F_BUD:   state_next = (rd_free && rd_ord == ford) ? S_U_RD : S_P_RD;
      S_F_NEXT:  state_next = S_F_LOOP;
      S_F_END:   state_next = S_DONE;
      S_P_RD:    state_next = S_P_WR;
      S_P_WR:    state_next = head_cur[MAX_ORDER] ? ret : S_P_HW;
      S_P_HW:    state_next = ret;
      S_U_RD:    state_next = S_U_P;
      S_U_P:     state_next = rd_prev[MAX_ORDER] ? S_U_N : S_U_PW;
      S_U_PW:    state_next = S_U_N;
      S_U_N:     state_next = un[MAX_ORDER] ? ret : S_U_NW;
      S_U_NW:    state_next = ret;
      S_FAIL:    state_next = S_DONE;
      S_DONE:    state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Page table port controls.
  always_comb begin
    we    = 1'b0;
    waddr = sp;
    wdata = rdata;
    re    = 1'b0;
    raddr = sp;
    case (state)
      S_CLR: begin
        we    = 1'b1;
        waddr = clr_cnt[AW-1:0];
        wdata = '0;
      end
      S_A_MRD: begin
        re    = 1'b1;
        raddr = blk;
      end
      S_A_MWR: begin
        we    = 1'b1;
        waddr = blk;
        wdata = {rd_next, rd_prev, aord, 1'b1, rd_free};
      end
      S_F_CHK: begin
        re    = 1'b1;
        raddr = page_r;
      end
      S_F_RD: begin
        we    = rd_use;
        waddr = fp;
        wdata = {rd_next, rd_prev, rd_ord, 1'b0, rd_free};
      end
      S_F_LOOP: begin
        re    = (ford < pool_ord);
        raddr = fp ^ (AW'(1) << ford);
      end
      S_P_RD, S_U_RD: begin
        re = 1'b1;
      end
      S_P_WR: begin
        we    = 1'b1;
        wdata = {head_cur, NIL, cur_ord, rd_use, 1'b1};
        re    = !head_cur[MAX_ORDER];
        raddr = head_cur[AW-1:0];
      end
      S_P_HW: begin
        we    = 1'b1;
        waddr = tmp_h[AW-1:0];
        wdata = {rd_next, LW'(sp), rd_ord, rd_use, rd_free};
      end
      S_U_P: begin
        we    = 1'b1;
        wdata = {rd_next, rd_prev, rd_ord, rd_use, 1'b0};
        re    = !rd_prev[MAX_ORDER];
        raddr = rd_prev[AW-1:0];
      end
      S_U_PW: begin
        we    = 1'b1;
        waddr = upr[AW-1:0];
        wdata = {un, rd_prev, rd_ord, rd_use, rd_free};
      end
      S_U_N: begin
        re    = !un[MAX_ORDER];
        raddr = un[AW-1:0];
      end
      S_U_NW: begin
        we    = 1'b1;
        waddr = un[AW-1:0];
        wdata = {rd_next, upr, rd_ord, rd_use, rd_free};
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      pool_pages <= LW'(1) << MAX_ORDER;
      pool_ord   <= OW'(TOP);
      report     <= 1'b0;
      clr_cnt    <= '0;
      for (int i = 0; i < NUM_LISTS; i++) begin
        heads[i] <= NIL;
      end
    end else begin
      state <= state_next;
      if (cfg_we) begin
        pool_pages <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          func_r <= func;
          req_r  <= request_pages;
          page_r <= page_index;
        end
        S_I_START: begin
          pool_ord <= cfg_ord;
          report   <= 1'b1;
          clr_cnt  <= '0;
          for (int i = 0; i < NUM_LISTS; i++) begin
            heads[i] <= NIL;
          end
        end
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          sp      <= '0;
          cur_ord <= pool_ord;
          ret     <= S_I_END;
        end
        S_I_END: begin
          fcount <= LW'(1) << pool_ord;
          ok_r   <= 1'b1;
          blk_r  <= '0;
        end
        S_A_CHK: aord <= ceil_ord;
        S_A_ORD: scan <= aord;
        S_A_SCAN: begin
          if (!head_scan[MAX_ORDER]) begin
            blk     <= head_scan[AW-1:0];
            sp      <= head_scan[AW-1:0];
            cur_ord <= scan;
            ret     <= S_A_SPLIT;
          end else begin
            scan <= scan + 1'b1;
          end
        end
        S_A_SPLIT: begin
          if (scan > aord) begin
            scan    <= scan - 1'b1;
            cur_ord <= scan - 1'b1;
            sp      <= blk + (AW'(1) << (scan - 1'b1));
            ret     <= S_A_SPLIT;
          end
        end
        S_A_MWR: begin
          fcount <= fcount - (LW'(1) << aord);
          ok_r   <= 1'b1;
          blk_r  <= blk;
        end
        S_F_CHK: fp <= page_r;
        S_F_RD: begin
          ford <= free_ord;
          if (rd_use) begin
            fcount <= fcount + (LW'(1) << free_ord);
          end
        end
        S_F_LOOP: begin
          fb <= fp ^ (AW'(1) << ford);
          if (ford >= pool_ord) begin
            sp      <= fp;
            cur_ord <= ford;
            ret     <= S_F_END;
          end
        end
        S_F_BUD: begin
          cur_ord <= ford;
          if (rd_free && rd_ord == ford) begin
            sp  <= fb;
            ret <= S_F_NEXT;
          end else begin
            sp  <= fp;
            ret <= S_F_END;
          end
        end
        S_F_NEXT: begin
          if (fb < fp) begin
            fp <= fb;
          end
          ford <= ford + 1'b1;
        end
        S_F_END: begin
          ok_r  <= 1'b1;
          blk_r <= '0;
        end
        S_P_WR: begin
          tmp_h               <= head_cur;
          heads[HW'(cur_ord)] <= LW'(sp);
        end
        S_U_P: begin
          un  <= rd_next;
          upr <= rd_prev;
          if (rd_prev[MAX_ORDER]) begin
            heads[HW'(cur_ord)] <= rd_next;
          end
        end
        S_FAIL: begin
          ok_r  <= 1'b0;
          blk_r <= '0;
        end
        default: begin
          report <= report;
        end
      endcase
    end
  end

  assign busy        = (state != S_IDLE);
  assign done        = (state == S_DONE);
  assign ok          = ok_r;
  assign block_index = blk_r;
  assign free_total  = fcount;

  // A result word always returns the block to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("result word not followed by idle");

  // The free count never exceeds the pool while idle.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (fcount <= (LW'(1) << pool_ord)))
    else $error("free page count above pool size");

  // A successful allocation returns a block aligned to its own size.
  a_aligned: assert property (@(posedge clk) disable iff (rst)
    (done && ok && func_r == FUNC_ALLOC) |-> ((blk_r & ((AW'(1) << aord) - 1'b1)) == '0))
    else $error("allocated block not aligned");

  // An accepted command always makes the block busy on the next cycle.
  a_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Testbench for buddy_page_allocator_core: drives allocate, free, init and invalid commands
// and checks each result word against a page-level model of the buddy allocator.
// Depends on bpa_pkg and the RTL of the core.

module tb;
  import bpa_pkg::*;

  localparam logic [1:0] FUNC_NONE = 2'd3;
  localparam int PAGES = 1 << MAX_ORDER_DEF;
  localparam int NIL = PAGES;
  localparam int CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic        ok;
    logic [13:0] blk;
    logic [14:0] fp;
  } alloc_word_t;

  class alloc_scoreboard;
    int          nxt[PAGES];
    int          prv[PAGES];
    int          page_ord[PAGES];
    bit          used[PAGES];
    bit          on_list[PAGES];
    int          head[NUM_LISTS_DEF];
    int          free_cnt;
    int          pool_ord;
    logic [14:0] pool_cfg;
    int          live[$];
    alloc_word_t pending[$];
    int          errors;

    function void put_block(int o, int p);
      nxt[p] = head[o];
      prv[p] = NIL;
      if (head[o] != NIL) prv[head[o]] = p;
      head[o] = p;
      on_list[p] = 1;
      page_ord[p] = o;
    endfunction

    function void take_block(int o, int p);
      int n;
      int pr;
      n = nxt[p];
      pr = prv[p];
      if (pr == NIL) head[o] = n;
      else nxt[pr] = n;
      if (n != NIL) prv[n] = pr;
      on_list[p] = 0;
    endfunction

    function void rebuild();
      int v;
      int o;
      v = int'(pool_cfg);
      o = 0;
      while (v > 1) begin
        v = v >> 1;
        o++;
      end
      if (o > MAX_ORDER_DEF) o = MAX_ORDER_DEF;
      if (o > NUM_LISTS_DEF - 1) o = NUM_LISTS_DEF - 1;
      for (int i = 0; i < PAGES; i++) begin
        page_ord[i] = 0;
        used[i] = 0;
        on_list[i] = 0;
      end
      for (int i = 0; i < NUM_LISTS_DEF; i++) head[i] = NIL;
      pool_ord = o;
      put_block(o, 0);
      free_cnt = 1 << o;
      live.delete();
    endfunction

    function new();
      pool_cfg = 15'd16384;
      errors = 0;
      rebuild();
    endfunction

    function bit grab(int req, output int where);
      int o;
      int i;
      int b;
      where = 0;
      if (req == 0) req = 1;
      if (req > free_cnt) return 0;
      o = 0;
      while ((1 << o) < req) o++;
      if (o > pool_ord) return 0;
      for (i = o; i <= pool_ord; i++)
        if (head[i] != NIL) break;
      if (i > pool_ord) return 0;
      b = head[i];
      take_block(i, b);
      while (i > o) begin
        i--;
        put_block(i, b + (1 << i));
      end
      page_ord[b] = o;
      used[b] = 1;
      free_cnt -= 1 << o;
      where = b;
      live.push_back(b);
      return 1;
    endfunction

    function bit give_back(int p);
      int o;
      int b;
      int hits[$];
      if (p >= (1 << pool_ord)) return 0;
      if (!used[p]) return 0;
      hits = live.find_first_index(x) with (x == p);
      if (hits.size() > 0) live.delete(hits[0]);
      o = page_ord[p];
      if (o > pool_ord) o = pool_ord;
      used[p] = 0;
      free_cnt += 1 << o;
      while (o < pool_ord) begin
        b = p ^ (1 << o);
        if (!on_list[b] || page_ord[b] != o) break;
        take_block(o, b);
        if (b < p) p = b;
        o++;
      end
      put_block(o, p);
      return 1;
    endfunction

    function void note_command(logic [1:0] f, logic [14:0] req, logic [13:0] page);
      alloc_word_t w;
      int where;
      w = '0;
      where = 0;
      case (f)
        FUNC_ALLOC: w.ok = grab(int'(req), where);
        FUNC_FREE:  w.ok = give_back(int'(page));
        FUNC_INIT: begin
          rebuild();
          w.ok = 1;
        end
        default: w.ok = 0;
      endcase
      w.blk = 14'(where);
      w.fp = 15'(free_cnt);
      pending.push_back(w);
    endfunction

    function void check_word(logic ok, logic [13:0] blk, logic [14:0] fp);
      alloc_word_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word: ok=%0d blk=%0d free=%0d",
                                   ok, blk, fp);
        return;
      end
      e = pending.pop_front();
      if (ok !== e.ok || blk !== e.blk || fp !== e.fp) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected ok=%0d blk=%0d free=%0d, got ok=%0d blk=%0d free=%0d",
                   e.ok, e.blk, e.fp, ok, blk, fp);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  func;
  logic [14:0] request_pages;
  logic [13:0] page_index;
  logic        done;
  logic        ok;
  logic [13:0] block_index;
  logic [14:0] free_total;
  logic        cfg_we;
  logic [14:0] cfg_data;

  alloc_scoreboard sb;
  int cycles;
  int burst_left;

  buddy_page_allocator_core i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .request_pages(request_pages), .page_index(page_index), .done(done), .ok(ok),
    .block_index(block_index), .free_total(free_total), .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("buddy_page_allocator_core verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_word(ok, block_index, free_total);
  end

  task automatic pause(int n);
    @(negedge clk);
    start = 0;
    repeat (n - 1) @(negedge clk);
  endtask

  // The sender runs in bursts; a gap of idle cycles comes before each one.
  task automatic send(logic [1:0] f, logic [14:0] req, logic [13:0] page);
    if (burst_left == 0) begin
      pause(int'($urandom_range(1, 30)));
      burst_left = $urandom_range(0, 3) == 0 ? int'($urandom_range(20, 60))
                                             : int'($urandom_range(1, 8));
    end
    burst_left--;
    @(negedge clk);
    func = f;
    request_pages = req;
    page_index = page;
    start = 1;
    do @(posedge clk); while (busy);
    sb.note_command(f, req, page);
  endtask

  task automatic drain();
    pause(1);
    while (sb.pending.size() != 0 || busy) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic set_pool(logic [14:0] v);
    drain();
    cfg_we = 1;
    cfg_data = v;
    sb.pool_cfg = v;
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic random_item();
    int r;
    int sel;
    r = int'($urandom_range(0, 99));
    if (r < 40) send(FUNC_ALLOC, 15'($urandom_range(1, 16)), 14'($urandom));
    else if (r < 47) send(FUNC_ALLOC, 15'($urandom_range(0, 32767)), 14'($urandom));
    else if (r < 52)
      send(FUNC_ALLOC, 15'($urandom_range(1, 1 << sb.pool_ord)), 14'($urandom));
    else if (r < 85) begin
      if (sb.live.size() > 0) begin
        sel = int'($urandom_range(0, sb.live.size() - 1));
        send(FUNC_FREE, 15'($urandom), 14'(sb.live[sel]));
      end else begin
        send(FUNC_FREE, 15'($urandom), 14'($urandom_range(0, 16383)));
      end
    end
    else if (r < 95) send(FUNC_FREE, 15'($urandom), 14'($urandom_range(0, 16383)));
    else if (r < 99) send(FUNC_NONE, 15'($urandom), 14'($urandom));
    else send(FUNC_INIT, 15'($urandom), 14'($urandom));
  endtask

  initial begin
    logic [14:0] pools[6];
    pools = '{15'd16384, 15'd1, 15'd0, 15'd32767, 15'd37, 15'd700};
    sb = new();
    cycles = 0;
    burst_left = 0;
    rst = 1;
    start = 0;
    func = FUNC_ALLOC;
    request_pages = 0;
    page_index = 0;
    cfg_we = 0;
    cfg_data = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Whole pool, then exhaustion, bad frees, merging back to one block, an invalid command and init.
    send(FUNC_ALLOC, 15'd16384, 14'd0);
    send(FUNC_ALLOC, 15'd1, 14'd0);
    send(FUNC_FREE, 15'd0, 14'd16383);
    send(FUNC_FREE, 15'd0, 14'd0);
    send(FUNC_FREE, 15'd0, 14'd0);
    send(FUNC_ALLOC, 15'd0, 14'd0);
    send(FUNC_ALLOC, 15'd3, 14'd0);
    send(FUNC_ALLOC, 15'd32767, 14'd0);
    send(FUNC_ALLOC, 15'd8193, 14'd0);
    send(FUNC_ALLOC, 15'd1, 14'd0);
    send(FUNC_ALLOC, 15'd1, 14'd0);
    send(FUNC_FREE, 15'd0, 14'd1);
    send(FUNC_FREE, 15'd0, 14'd4);
    send(FUNC_FREE, 15'd0, 14'd0);
    send(FUNC_FREE, 15'd0, 14'd2);
    send(FUNC_FREE, 15'd0, 14'd3);
    send(FUNC_NONE, 15'h7fff, 14'h3fff);
    send(FUNC_ALLOC, 15'd8192, 14'd0);
    send(FUNC_INIT, 15'd0, 14'd0);
    send(FUNC_ALLOC, 15'd16384, 14'd0);
    send(FUNC_FREE, 15'd0, 14'd0);

    foreach (pools[i]) begin
      set_pool(pools[i]);
      send(FUNC_INIT, 15'($urandom), 14'($urandom));
      repeat (170) random_item();
    end

    drain();
    if (sb.errors == 0) $display("buddy_page_allocator_core verification clean");
    else $display("buddy_page_allocator_core verification failed");
    $finish;
  end

endmodule

FILE: buddy_page_allocator_core.f
hw/rtl/bpa_pkg.sv
hw/rtl/bpa_page_ram.sv
hw/rtl/buddy_page_allocator_core.sv
tb/sv/tb.sv
